### hdl/epcc_pkg.sv
// Package for the element/plane crossing classifier.
// Holds sizes, derived widths, request op codes and the sequencer state type.
// No dependencies; the interfaces, the top level and the testbench import it.
package epcc_pkg;

   localparam int NumPlanes  = 16;
   localparam int CoordBits  = 32;

   localparam int FieldWidth    = 32;
   localparam int SlotWidth     = 4;
   localparam int TagWidth      = 16;
   localparam int ActWidth      = 5;
   localparam int IndexOutWidth = 4;

   localparam int CoordWidth = (CoordBits < 32) ? CoordBits : 32;
   localparam int IdxWidth   = (NumPlanes > 1) ? $clog2(NumPlanes) : 1;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int ProdWidth  = DiffWidth + CoordWidth;
   localparam int SumWidth   = ProdWidth + 2;
   localparam int CmpWidth   = (ActWidth > IdxWidth + 1) ? ActWidth : IdxWidth + 1;
   localparam int RamWidth   = 6 * CoordWidth + TagWidth;

   localparam logic OpLoad = 1'b0;
   localparam logic OpNode = 1'b1;

   typedef enum logic [2:0] {
      StIdle,
      StSweep,
      StDrain,
      StLookup,
      StResult
   } state_type;

endpackage

### hdl/epcc_if.sv
// Valid/ready channel interfaces for the crossing classifier.
// Depends on epcc_pkg for the field widths.
interface epcc_req_if;
   import epcc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [SlotWidth-1:0]         slot;
   logic signed [FieldWidth-1:0] coord_x;
   logic signed [FieldWidth-1:0] coord_y;
   logic signed [FieldWidth-1:0] coord_z;
   logic signed [FieldWidth-1:0] normal_x;
   logic signed [FieldWidth-1:0] normal_y;
   logic signed [FieldWidth-1:0] normal_z;
   logic [TagWidth-1:0]          section_tag;
   logic                         last_node;

   modport source (
      output valid, op, slot, coord_x, coord_y, coord_z,
             normal_x, normal_y, normal_z, section_tag, last_node,
      input  ready
   );
   modport sink (
      input  valid, op, slot, coord_x, coord_y, coord_z,
             normal_x, normal_y, normal_z, section_tag, last_node,
      output ready
   );
endinterface

interface epcc_rsp_if;
   import epcc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     found;
   logic [IndexOutWidth-1:0] section_index;
   logic [TagWidth-1:0]      result_tag;

   modport source (
      output valid, found, section_index, result_tag,
      input  ready
   );
   modport sink (
      input  valid, found, section_index, result_tag,
      output ready
   );
endinterface

### hdl/element_plane_crossing_classifier.sv
// Top level of the element/plane crossing classifier.
// Depends on epcc_pkg, the channel interfaces in epcc_if and the plane table RAM epcc_ram.
//
//   Channel    Direction  Handshake              Carries
//   req_port   in         valid/ready            plane load or element node request
//   rsp_port   out        valid/ready            found, section_index, result_tag
//   csr_*      in         write enable only      active_planes (5 bits)
//
// A plane load request is written into the plane table at the edge that accepts it. A node
// request holds the block from the edge that accepts it to the next edge that can accept:
// the accepting cycle, a sweep in which the sequencer reads each plane from the table RAM
// in turn, and a drain of the RAM read and the dot-product pipeline (subtract, three
// multipliers, sum and sign). A last node then passes through the tag lookup and result
// states, and waits in the result state while the response register stays full. Reset
// is synchronous and clears the sequencer, the side bits and the active plane count; the
// plane table holds garbage until loaded. A stall on rsp_port only holds a last node in
// the result state; loads and other nodes proceed while a response waits.
module element_plane_crossing_classifier (
   input  logic                          clock,
   input  logic                          reset,
   epcc_req_if.sink                      req_port,
   epcc_rsp_if.source                    rsp_port,
   input  logic                          csr_wr_en,
   input  logic [epcc_pkg::ActWidth-1:0] csr_wr_data
);
   import epcc_pkg::*;

   // Sequencer.
   state_type               state_ff, state_in;
   logic [IdxWidth-1:0]     cnt_ff, cnt_in;
   logic                    sweep_done;
   logic                    pipe_empty;

   // Configuration and captured node.
   logic [ActWidth-1:0]     active_ff;
   logic [CoordWidth-1:0]   node_ff [3];
   logic                    last_ff;

   // Request decode and plane table port.
   logic                    req_accept;
   logic                    load_accept;
   logic                    node_accept;
   logic                    ram_we;
   logic [IdxWidth-1:0]     ram_waddr;
   logic [RamWidth-1:0]     ram_wdata;
   logic [IdxWidth-1:0]     ram_raddr;
   logic [RamWidth-1:0]     ram_rdata;

   // Dot-product pipeline.
   logic                        rd_valid_ff;
   logic [IdxWidth-1:0]         rd_idx_ff;
   logic                        s1_valid_ff;
   logic [IdxWidth-1:0]         s1_idx_ff;
   logic signed [DiffWidth-1:0] diff_ff [3];
   logic signed [DiffWidth-1:0] diff_in [3];
   logic signed [CoordWidth-1:0] norm_ff [3];
   logic                        s2_valid_ff;
   logic [IdxWidth-1:0]         s2_idx_ff;
   logic signed [ProdWidth-1:0] prod_ff [3];
   logic signed [ProdWidth-1:0] prod_in [3];
   logic signed [SumWidth-1:0]  sum;
   logic                        pos;

   // Element state and report.
   logic [NumPlanes-1:0]    first_ff;
   logic [NumPlanes-1:0]    crossed_ff;
   logic                    open_ff;
   logic [NumPlanes-1:0]    mask;
   logic [NumPlanes-1:0]    hits;
   logic                    hit_any;
   logic [IdxWidth-1:0]     hit_idx;
   logic                    found_ff;
   logic [IdxWidth-1:0]     hit_idx_ff;

   // Response register.
   logic                     rsp_load;
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic [IndexOutWidth-1:0] rsp_index_ff;
   logic [TagWidth-1:0]      rsp_tag_ff;

   //------------------------------------------------------------------
   // Request decode. The RAM word holds the offset in the low three fields,
   // the normal above it and the tag at the top.
   //------------------------------------------------------------------
   assign req_accept  = req_port.valid && req_port.ready;
   assign load_accept = req_accept && (req_port.op == OpLoad);
   assign node_accept = req_accept && (req_port.op == OpNode);
   assign ram_we      = load_accept && (int'(req_port.slot) < NumPlanes);
   assign ram_waddr   = IdxWidth'(req_port.slot);
   assign ram_wdata   = {req_port.section_tag,
                         req_port.normal_z[CoordWidth-1:0],
                         req_port.normal_y[CoordWidth-1:0],
                         req_port.normal_x[CoordWidth-1:0],
                         req_port.coord_z[CoordWidth-1:0],
                         req_port.coord_y[CoordWidth-1:0],
                         req_port.coord_x[CoordWidth-1:0]};

   epcc_ram #(
      .Width (RamWidth),
      .Depth (NumPlanes)
   ) u_plane_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   //------------------------------------------------------------------
   // Sequencer: next state.
   //------------------------------------------------------------------
   assign sweep_done = (cnt_ff == IdxWidth'(NumPlanes - 1));
   assign pipe_empty = !rd_valid_ff && !s1_valid_ff && !s2_valid_ff;
   assign rsp_load   = (state_ff == StResult) && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (node_accept) begin
               state_in = StSweep;
            end
         end
         StSweep: begin
            if (sweep_done) begin
               state_in = StDrain;
            end
         end
         StDrain: begin
            if (pipe_empty) begin
               state_in = last_ff ? StLookup : StIdle;
            end
         end
         StLookup: begin
            state_in = StResult;
         end
         StResult: begin
            if (rsp_load) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   //------------------------------------------------------------------
   // Sequencer: outputs. During the sweep the counter walks the table; in
   // the lookup and result states the read address holds the crossed plane
   // so that its tag stays on the RAM output until the response is loaded.
   //------------------------------------------------------------------
   always_comb begin
      req_port.ready = 1'b0;
      cnt_in         = '0;
      ram_raddr      = hit_idx_ff;
      case (state_ff)
         StIdle: begin
            req_port.ready = 1'b1;
         end
         StSweep: begin
            ram_raddr = cnt_ff;
            cnt_in    = IdxWidth'(cnt_ff + 1'b1);
         end
         StDrain, StLookup, StResult: begin
            ram_raddr = hit_idx_ff;
         end
         default: begin
            req_port.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   //------------------------------------------------------------------
   // Configuration register and captured node.
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (node_accept) begin
         node_ff[0] <= req_port.coord_x[CoordWidth-1:0];
         node_ff[1] <= req_port.coord_y[CoordWidth-1:0];
         node_ff[2] <= req_port.coord_z[CoordWidth-1:0];
         last_ff    <= req_port.last_node;
      end
   end

   //------------------------------------------------------------------
   // Dot-product pipeline. Stage one forms node minus offset at one bit more
   // than the coordinates, stage two the three exact products, stage three
   // their sum. Only a strictly positive sum counts as the positive side.
   //------------------------------------------------------------------
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff_in[k] = $signed({node_ff[k][CoordWidth-1], node_ff[k]})
                    - $signed({ram_rdata[k*CoordWidth + CoordWidth - 1],
                               ram_rdata[k*CoordWidth +: CoordWidth]});
         prod_in[k] = ProdWidth'(diff_ff[k]) * ProdWidth'(norm_ff[k]);
      end
   end

   assign sum = SumWidth'(prod_ff[0]) + SumWidth'(prod_ff[1]) + SumWidth'(prod_ff[2]);
   assign pos = !sum[SumWidth-1] && (sum != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == StSweep);
         s1_valid_ff <= rd_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff;
      s1_idx_ff <= rd_idx_ff;
      s2_idx_ff <= s1_idx_ff;
      for (int k = 0; k < 3; k++) begin
         diff_ff[k] <= diff_in[k];
         norm_ff[k] <= $signed(ram_rdata[(k + 3)*CoordWidth +: CoordWidth]);
         prod_ff[k] <= prod_in[k];
      end
   end

   //------------------------------------------------------------------
   // Element side tracking. The first node of an element records its side
   // for every plane; later nodes mark a plane crossed when they land on the
   // other side. All slots are tracked, so a change of the active count
   // between nodes only affects which slots are reported.
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= '0;
         crossed_ff <= '0;
         open_ff    <= 1'b0;
      end else if (rsp_load) begin
         first_ff   <= '0;
         crossed_ff <= '0;
         open_ff    <= 1'b0;
      end else begin
         if (s2_valid_ff) begin
            if (!open_ff) begin
               first_ff[s2_idx_ff]   <= pos;
               crossed_ff[s2_idx_ff] <= 1'b0;
            end else begin
               crossed_ff[s2_idx_ff] <= crossed_ff[s2_idx_ff] | (pos ^ first_ff[s2_idx_ff]);
            end
         end
         if ((state_ff == StDrain) && pipe_empty && !last_ff) begin
            open_ff <= 1'b1;
         end
      end
   end

   //------------------------------------------------------------------
   // Report: the lowest crossed slot below the active count. A single-node
   // element never reaches here with a crossed bit set, since the first node
   // clears them all.
   //------------------------------------------------------------------
   always_comb begin
      for (int s = 0; s < NumPlanes; s++) begin
         mask[s] = CmpWidth'(s) < CmpWidth'(active_ff);
      end
      hits    = crossed_ff & mask;
      hit_any = |hits;
      hit_idx = '0;
      for (int s = NumPlanes - 1; s >= 0; s--) begin
         if (hits[s]) begin
            hit_idx = IdxWidth'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == StDrain) && pipe_empty) begin
         found_ff   <= hit_any;
         hit_idx_ff <= hit_idx;
      end
   end

   //------------------------------------------------------------------
   // Response register. The tag comes straight off the table RAM, whose read
   // address has held the crossed slot since the lookup state.
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_index_ff <= found_ff ? IndexOutWidth'(hit_idx_ff) : '0;
         rsp_tag_ff   <= found_ff ? ram_rdata[RamWidth-1 -: TagWidth] : '0;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.found         = rsp_found_ff;
   assign rsp_port.section_index = rsp_index_ff;
   assign rsp_port.result_tag    = rsp_tag_ff;

endmodule

### hdl/epcc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module epcc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                           wr_data,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                           rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### verif/element_plane_crossing_classifier_test.sv
// Self-checking testbench for element_plane_crossing_classifier.
// Drives plane loads and element nodes through the request channel and checks each
// crossing verdict; depends on epcc_pkg and the epcc_req_if and epcc_rsp_if interfaces.
`timescale 1ns / 1ps

module element_plane_crossing_classifier_test;
   import epcc_pkg::*;

   // One request as the block sees it. Load requests use every field except last_node;
   // node requests use the coordinates and last_node only.
   typedef struct packed {
      logic                         op;
      logic [SlotWidth-1:0]         slot;
      logic signed [FieldWidth-1:0] coord_x;
      logic signed [FieldWidth-1:0] coord_y;
      logic signed [FieldWidth-1:0] coord_z;
      logic signed [FieldWidth-1:0] normal_x;
      logic signed [FieldWidth-1:0] normal_y;
      logic signed [FieldWidth-1:0] normal_z;
      logic [TagWidth-1:0]          section_tag;
      logic                         last_node;
   } crossing_request_type;

   typedef struct packed {
      logic                     found;
      logic [IndexOutWidth-1:0] section_index;
      logic [TagWidth-1:0]      result_tag;
   } verdict_type;

   typedef struct packed {
      logic signed [FieldWidth-1:0] x;
      logic signed [FieldWidth-1:0] y;
      logic signed [FieldWidth-1:0] z;
   } point_type;

   localparam logic signed [FieldWidth-1:0] MinCoord = {1'b1, {(FieldWidth - 1){1'b0}}};
   localparam logic signed [FieldWidth-1:0] MaxCoord = {1'b0, {(FieldWidth - 1){1'b1}}};
   localparam logic signed [FieldWidth-1:0] OneQ     = 32'sh0001_0000;

   localparam int MaxGap        = 12;
   localparam int AnchorCount   = 8;
   // A node sweeps every plane plus the pipeline, and a last node adds the tag lookup.
   // Twice that figure covers a node that is still in flight after the last result.
   localparam int DrainCycles   = 2 * (NumPlanes + 6);
   localparam int WatchdogLimit = 2000;
   localparam int PhaseItems    = 115;

   // Clock, reset and every block input start at known values at time zero.
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [ActWidth-1:0] csr_wr_data = '0;

   crossing_request_type req_drive = '0;
   logic                 req_valid = 1'b0;
   logic                 rsp_ready = 1'b0;

   epcc_req_if req_chan ();
   epcc_rsp_if rsp_chan ();

   assign req_chan.valid       = req_valid;
   assign req_chan.op          = req_drive.op;
   assign req_chan.slot        = req_drive.slot;
   assign req_chan.coord_x     = req_drive.coord_x;
   assign req_chan.coord_y     = req_drive.coord_y;
   assign req_chan.coord_z     = req_drive.coord_z;
   assign req_chan.normal_x    = req_drive.normal_x;
   assign req_chan.normal_y    = req_drive.normal_y;
   assign req_chan.normal_z    = req_drive.normal_z;
   assign req_chan.section_tag = req_drive.section_tag;
   assign req_chan.last_node   = req_drive.last_node;
   assign rsp_chan.ready       = rsp_ready;

   element_plane_crossing_classifier uut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_chan),
      .rsp_port    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Stimulus bookkeeping. The initial block fills pending_requests; the driver drains it.
   crossing_request_type pending_requests[$];
   verdict_type          expected_verdicts[$];
   int                   requests_queued   = 0;
   int                   requests_accepted = 0;
   logic                 sender_idling     = 1'b0;
   logic                 receiver_idling   = 1'b0;
   point_type            anchors[AnchorCount];

   // Shadow of the block: the plane table, the side tracking of the open element and the
   // active plane count. The table keeps whole load requests since they carry every field.
   crossing_request_type plane_table[NumPlanes];
   logic [NumPlanes-1:0] first_sides   = '0;
   logic [NumPlanes-1:0] crossed_sides = '0;
   logic                 element_open  = 1'b0;
   logic [ActWidth-1:0]  plane_count_setting;

   int loads_applied   = 0;
   int nodes_applied   = 0;
   int elements_closed = 0;
   int elements_found  = 0;
   int settings_used   = 0;
   int error_count     = 0;

   // The register mirror follows the write port, so the shadow sees exactly the value
   // that the block latches, at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         plane_count_setting <= '0;
      end else if (csr_wr_en) begin
         plane_count_setting <= csr_wr_data;
      end
   end

   function automatic logic signed [127:0] widen(logic signed [FieldWidth-1:0] v);
      return 128'(v);
   endfunction

   // The side test is exact: the difference needs 33 bits and each product 65, so a
   // 128-bit signed sum can never overflow. A node lying on the plane gives zero and
   // therefore lands on the non-positive side.
   function automatic logic plane_positive(crossing_request_type node,
                                           crossing_request_type plane);
      logic signed [127:0] acc;
      acc = (widen(node.coord_x) - widen(plane.coord_x)) * widen(plane.normal_x)
          + (widen(node.coord_y) - widen(plane.coord_y)) * widen(plane.normal_y)
          + (widen(node.coord_z) - widen(plane.coord_z)) * widen(plane.normal_z);
      return acc > 0;
   endfunction

   // Applies one accepted request to the shadow and, at a last node, queues the verdict
   // the block has to return: the lowest active slot whose sides differ among the nodes.
   function automatic void classify_request(crossing_request_type r);
      logic [NumPlanes-1:0] sides;
      verdict_type          verdict;
      int                   limit;
      if (r.op == OpLoad) begin
         // The last_node bit of a load is ignored; a load inside an element simply
         // changes the plane that the later nodes are tested against.
         plane_table[r.slot] = r;
         loads_applied++;
         return;
      end
      nodes_applied++;
      for (int s = 0; s < NumPlanes; s++) begin
         sides[s] = plane_positive(r, plane_table[s]);
      end
      if (!element_open) begin
         first_sides   = sides;
         crossed_sides = '0;
         element_open  = 1'b1;
      end else begin
         crossed_sides = crossed_sides | (sides ^ first_sides);
      end
      if (!r.last_node) begin
         return;
      end
      // Sides are tracked for every slot, so the count in force at the last node alone
      // decides which slots may be reported. Counts above the table size are clamped.
      limit = (int'(plane_count_setting) < NumPlanes) ? int'(plane_count_setting) : NumPlanes;
      verdict = '0;
      for (int s = 0; s < limit; s++) begin
         if (crossed_sides[s] && !verdict.found) begin
            verdict.found         = 1'b1;
            verdict.section_index = IndexOutWidth'(s);
            verdict.result_tag    = plane_table[s].section_tag;
         end
      end
      expected_verdicts.insert(expected_verdicts.size(), verdict);
      elements_closed++;
      if (verdict.found) begin
         elements_found++;
      end
      element_open  = 1'b0;
      first_sides   = '0;
      crossed_sides = '0;
   endfunction

   // Request driver. A request is presented until accepted; after acceptance the next one
   // is presented at once or after a gap, so valid changes at most once per edge.
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_chan.ready) begin
            classify_request(req_drive);
            requests_accepted++;
         end
         if (!req_valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_drive <= pending_requests.pop_front();
               req_valid <= 1'b1;
               if (sender_idling && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, MaxGap);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. It also owns the ready line and throttles it in random bursts.
   int stall_left = 0;

   always @(posedge clock) begin : result_monitor
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t ns: result with none expected: found=%0d index=%0d tag=0x%h",
                        $time, rsp_chan.found, rsp_chan.section_index, rsp_chan.result_tag);
               error_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_chan.found !== want.found) begin
                  $display("%0t ns: found expected %0d actual %0d",
                           $time, want.found, rsp_chan.found);
                  error_count++;
               end
               if (rsp_chan.section_index !== want.section_index) begin
                  $display("%0t ns: section_index expected %0d actual %0d",
                           $time, want.section_index, rsp_chan.section_index);
                  error_count++;
               end
               if (rsp_chan.result_tag !== want.result_tag) begin
                  $display("%0t ns: result_tag expected 0x%h actual 0x%h",
                           $time, want.result_tag, rsp_chan.result_tag);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (receiver_idling && $urandom_range(0, 4) == 0) begin
               stall_left = $urandom_range(1, MaxGap);
            end
         end
      end
   end

   // Watchdog: a stretch with no accepted request and no accepted result means a hang.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_chan.ready) || (rsp_chan.valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
         $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                  $time, WatchdogLimit, expected_verdicts.size());
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus helpers.
   function automatic point_type pt(logic signed [FieldWidth-1:0] x,
                                    logic signed [FieldWidth-1:0] y,
                                    logic signed [FieldWidth-1:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   // Style 0 is a full-range value, style 1 a value within a few units of zero, and any
   // other style one of the corner values of the Q16.16 range.
   function automatic logic signed [FieldWidth-1:0] pick_value(int style);
      logic signed [FieldWidth-1:0] v;
      if (style == 0) begin
         v = $urandom();
      end else if (style == 1) begin
         v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      end else begin
         case ($urandom_range(0, 4))
            0:       v = MinCoord;
            1:       v = MaxCoord;
            2:       v = '0;
            3:       v = -1;
            default: v = OneQ;
         endcase
      end
      return v;
   endfunction

   function automatic point_type random_point();
      return pt(pick_value($urandom_range(0, 2)), pick_value($urandom_range(0, 2)),
                pick_value($urandom_range(0, 2)));
   endfunction

   // Anchors are shared between plane offsets and nodes, so that nodes land exactly on
   // planes far more often than chance would allow.
   function automatic void refresh_anchors();
      for (int a = 0; a < AnchorCount; a++) begin
         anchors[a] = random_point();
      end
   endfunction

   function automatic void queue_load(int slot, point_type offset, point_type normal,
                                      logic [TagWidth-1:0] tag, logic last);
      crossing_request_type r;
      r             = '0;
      r.op          = OpLoad;
      r.slot        = SlotWidth'(slot);
      r.coord_x     = offset.x;
      r.coord_y     = offset.y;
      r.coord_z     = offset.z;
      r.normal_x    = normal.x;
      r.normal_y    = normal.y;
      r.normal_z    = normal.z;
      r.section_tag = tag;
      r.last_node   = last;
      pending_requests.insert(pending_requests.size(), r);
      requests_queued++;
   endfunction

   // Node requests carry random junk in the load-only fields, which the block must ignore.
   function automatic void queue_node(point_type p, logic last);
      crossing_request_type r;
      r             = '0;
      r.op          = OpNode;
      r.slot        = SlotWidth'($urandom());
      r.coord_x     = p.x;
      r.coord_y     = p.y;
      r.coord_z     = p.z;
      r.normal_x    = $urandom();
      r.normal_y    = $urandom();
      r.normal_z    = $urandom();
      r.section_tag = TagWidth'($urandom());
      r.last_node   = last;
      pending_requests.insert(pending_requests.size(), r);
      requests_queued++;
   endfunction

   // A random plane: general, zero normal (a plane that is never crossed), or aligned
   // with one axis so that nodes sharing one coordinate with the offset lie on it.
   function automatic void queue_plane_load(int slot);
      point_type offset;
      point_type normal;
      int        kind;
      int        axis;
      offset = ($urandom_range(0, 2) == 0) ? anchors[$urandom_range(0, AnchorCount - 1)]
                                            : random_point();
      normal = random_point();
      kind   = $urandom_range(0, 9);
      axis   = $urandom_range(0, 2);
      if (kind == 0) begin
         normal = '0;
      end else if (kind <= 2) begin
         if (axis != 0) normal.x = '0;
         if (axis != 1) normal.y = '0;
         if (axis != 2) normal.z = '0;
      end
      queue_load(slot, offset, normal, TagWidth'($urandom()), logic'($urandom_range(0, 1)));
   endfunction

   // An element is a cluster of nodes around a center. The spread runs from a few LSBs,
   // which seldom crosses anything, up to the full range, which crosses most planes.
   function automatic int unsigned scatter(int unsigned spread);
      if (spread == 0) begin
         return $urandom();
      end
      return $urandom_range(0, 2 * spread) - spread;
   endfunction

   function automatic void queue_element(int nodes, logic close);
      point_type   center;
      point_type   p;
      int unsigned spread;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         center = anchors[$urandom_range(0, AnchorCount - 1)];
      end else if (pick < 6) begin
         center = pt(pick_value(1), pick_value(1), pick_value(1));
      end else begin
         center = random_point();
      end
      case ($urandom_range(0, 3))
         0:       spread = 16;
         1:       spread = 32'h0001_0000;
         2:       spread = 32'h0100_0000;
         default: spread = 0;
      endcase
      for (int i = 0; i < nodes; i++) begin
         if (i > 0 && $urandom_range(0, 11) == 0) begin
            queue_plane_load($urandom_range(0, NumPlanes - 1));
         end
         if ($urandom_range(0, 4) == 0) begin
            p = anchors[$urandom_range(0, AnchorCount - 1)];
         end else begin
            p.x = center.x + scatter(spread);
            p.y = center.y + scatter(spread);
            p.z = center.z + scatter(spread);
         end
         queue_node(p, close && (i == nodes - 1));
      end
   endfunction

   // Quiet means every request taken and every verdict returned. A node that closes no
   // element may still be sweeping, so the drain time follows before anything else.
   task automatic wait_until_quiet();
      while (pending_requests.size() != 0 || requests_accepted != requests_queued ||
             expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   // One phase: the active plane count is changed only while the block is quiet, then a
   // batch of random traffic is queued. Leaving an element open carries it across the
   // next count change, so the count in force at its last node has to decide.
   task automatic run_phase(int setting, int item_count, logic leave_open, logic with_idling);
      int target;
      int nodes;
      wait_until_quiet();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ActWidth'(setting);
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      sender_idling   <= with_idling;
      receiver_idling <= with_idling;
      settings_used++;
      refresh_anchors();
      target = requests_queued + item_count;
      while (requests_queued < target) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_plane_load($urandom_range(0, NumPlanes - 1));
         end else begin
            nodes = ($urandom_range(0, 9) == 0) ? 1
                  : ($urandom_range(0, 9) == 0) ? 12 : $urandom_range(2, 6);
            queue_element(nodes, 1'b1);
         end
      end
      if (leave_open) begin
         queue_element(2, 1'b0);
      end
   endtask

   // Active plane counts for the random phases: both ends of the range, small counts
   // where only the first slots may report, and a few in between. The last phase runs
   // without idling on either side.
   int   phase_setting[10] = '{0, 1, 16, 2, 7, 16, 15, 3, 12, 16};
   logic phase_idling[10]  = '{1, 1, 0, 1, 1, 1, 0, 1, 1, 0};
   logic phase_open[10]    = '{0, 0, 1, 0, 0, 1, 0, 0, 0, 0};

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part with every plane tested. All sixteen slots are loaded before the
      // first node, so no node is ever tested against an unwritten plane.
      run_phase(NumPlanes, 0, 1'b0, 1'b1);
      // Plane x = 0, with the widest tag.
      queue_load(0, pt(0, 0, 0), pt(OneQ, 0, 0), 16'hFFFF, 1'b0);
      // Offset and normal at opposite corners: the widest possible products.
      queue_load(1, pt(MaxCoord, MaxCoord, MaxCoord), pt(MinCoord, MinCoord, MinCoord),
                 16'h0000, 1'b1);
      queue_load(2, pt(MinCoord, MinCoord, MinCoord), pt(MaxCoord, MaxCoord, MaxCoord),
                 16'h8001, 1'b0);
      // A zero normal puts every node on the plane, so the slot can never be crossed.
      queue_load(3, random_point(), pt(0, 0, 0), 16'h7FFE, 1'b0);
      queue_load(4, pt(0, 0, 0), pt(0, 0, -OneQ), 16'h1234, 1'b0);
      for (int s = 5; s < NumPlanes; s++) begin
         queue_plane_load(s);
      end
      // An element of a single node never matches.
      queue_node(pt(OneQ, OneQ, OneQ), 1'b1);
      // Straddles the plane x = 0.
      queue_node(pt(-OneQ, 0, 0), 1'b0);
      queue_node(pt(OneQ, 0, 0), 1'b1);
      // One node lies on x = 0 and the other below it: both count as the same side.
      queue_node(pt(0, 5, 5), 1'b0);
      queue_node(pt(-OneQ, 3, 3), 1'b1);
      // Corner nodes, one of them exactly on the offset of slot 1.
      queue_node(pt(MaxCoord, MaxCoord, MaxCoord), 1'b0);
      queue_node(pt(MinCoord, MinCoord, MinCoord), 1'b1);
      queue_node(pt(MinCoord, MaxCoord, MinCoord), 1'b0);
      queue_node(pt(MaxCoord, MinCoord, MaxCoord), 1'b0);
      queue_node(pt(0, 0, 0), 1'b1);
      // A load between two nodes applies to the later node only.
      queue_node(pt(2 * OneQ, 1, 1), 1'b0);
      queue_load(4, pt(0, 0, 0), pt(-OneQ, 0, 0), 16'h5A5A, 1'b1);
      queue_node(pt(-2 * OneQ, 1, 1), 1'b1);
      // Smallest nonzero distances on either side of the origin.
      queue_node(pt(-1, -1, -1), 1'b0);
      queue_node(pt(1, 1, 1), 1'b1);

      for (int p = 0; p < 10; p++) begin
         run_phase(phase_setting[p], PhaseItems, phase_open[p], phase_idling[p]);
      end

      wait_until_quiet();
      $display("Run covered %0d plane loads and %0d nodes under %0d active plane counts.",
               loads_applied, nodes_applied, settings_used);
      $display("%0d elements closed, %0d of them crossed an active plane; %0d mismatches.",
               elements_closed, elements_found, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
